// ----- rtl/mmh_pkg.sv -----
// Package for the min-max heap: sizes, op codes, status codes and index helpers.
// No dependencies; used by every rtl file.
package mmh_pkg;
    localparam int CAPACITY = 4096;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_EXT_MIN = 3'd1;
    localparam logic [2:0] OP_EXT_MAX = 3'd2;
    localparam logic [2:0] OP_PEEK_MIN = 3'd3;
    localparam logic [2:0] OP_PEEK_MAX = 3'd4;
    localparam logic [2:0] OP_SIZE    = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // min level when bit length of i+1 is odd
    function automatic logic on_min_level(input logic [CW:0] i);
        logic [CW:0] v;
        logic        m;
        v = i + 1'b1;
        m = 1'b0;
        for (int b = 0; b <= CW; b++)
            if (v[b]) m = (b % 2) == 0;
        return m;
    endfunction
endpackage

// ----- rtl/mmh_store.sv -----
// Key store memory for the min-max heap: one write port, one registered read port.
// Depends on mmh_pkg.
module mmh_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [mmh_pkg::AW-1:0]    waddr,
    input  logic signed [31:0]        wdata,
    input  logic [mmh_pkg::AW-1:0]    raddr,
    output logic signed [31:0]        rdata
);
    logic signed [31:0] mem [mmh_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/double_ended_priority_queue.sv -----
// Top level of the min-max heap: sequencer driving the key store's write and read ports and one comparator.
// Depends on mmh_pkg and mmh_store.
// Size, clear and unused ops finish straight from accept; peek reads the root, and for max
// also the max-level children; insert climbs by parent and grandparent steps; extract moves
// the last entry into the hole and sifts it down by child and grandchild steps.
// One request at a time; s_tready low from accept until the result beat is taken.
// rst_n asynchronous, clears count and control only.
module double_ended_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[2:0], key[34:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], result_key[33:2], entry_count[46:34], pad
);
    localparam int AW = mmh_pkg::AW;
    localparam int CW = mmh_pkg::CW;
    localparam int XW = CW + 3;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RDW, S_ROOT, S_MAXA, S_MAXB, S_MAXW, S_PICK,
        S_UPRD, S_UPW, S_UPCMP, S_CLRD, S_CLW, S_CLCMP,
        S_LASTRD, S_LASTW, S_DNSTART, S_DNCRD, S_DNCW, S_DNCMP, S_DNSWAP,
        S_DNPRD, S_DNPW, S_DNPCMP, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;       // key being moved
    logic signed [31:0] best_reg, best_next;     // extreme descendant key
    logic [XW-1:0]      i_reg, i_next;           // current hole
    logic [XW-1:0]      m_reg, m_next;           // chosen descendant index
    logic [XW-1:0]      c_reg, c_next;           // candidate scanned
    logic [2:0]         k_reg, k_next;
    logic               mn_reg, mn_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] res_reg, res_next;
    logic               ov_reg, ov_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic signed [31:0] wdata, rdata;

    mmh_store u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // shared comparator
    logic signed [31:0] ca, cb;
    logic               lt;
    assign lt = ca < cb;

    logic [XW-1:0] par_i, gp_i, cand;
    logic [XW-1:0] cnt_x;
    assign cnt_x = XW'(count_reg);
    assign par_i = (i_reg - 1'b1) >> 1;
    assign gp_i  = (par_i - 1'b1) >> 1;
    // next candidate after the one at k_reg
    always_comb
    begin
        case (k_reg)
            3'd0:    cand = (i_reg << 1) + XW'(2);
            3'd1:    cand = (i_reg << 2) + XW'(3);
            3'd2:    cand = (i_reg << 2) + XW'(4);
            3'd3:    cand = (i_reg << 2) + XW'(5);
            default: cand = (i_reg << 2) + XW'(6);
        endcase
    end

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, count_reg, res_reg, status_reg};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        best_next   = best_reg;
        i_next      = i_reg;
        m_next      = m_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        mn_next     = mn_reg;
        count_next  = count_reg;
        status_next = status_reg;
        res_next    = res_reg;
        ov_next     = ov_reg;
        we          = 1'b0;
        waddr       = i_reg[AW-1:0];
        wdata       = key_reg;
        raddr       = c_reg[AW-1:0];
        ca          = key_reg;
        cb          = rdata;
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_next     = s_tdata[2:0];
                    key_next    = s_tdata[34:3];
                    status_next = mmh_pkg::ST_OK;
                    res_next    = '0;
                    state_next  = S_DONE;
                    case (s_tdata[2:0])
                        mmh_pkg::OP_INSERT:
                            if (count_reg == CW'(mmh_pkg::CAPACITY))
                                status_next = mmh_pkg::ST_FULL;
                            else
                            begin
                                i_next     = cnt_x;
                                count_next = count_reg + 1'b1;
                                state_next = (count_reg == '0) ? S_RD : S_UPRD;
                                if (count_reg == '0)
                                begin
                                    we    = 1'b1;
                                    waddr = '0;
                                    wdata = s_tdata[34:3];
                                end
                            end
                        mmh_pkg::OP_EXT_MIN, mmh_pkg::OP_EXT_MAX,
                        mmh_pkg::OP_PEEK_MIN, mmh_pkg::OP_PEEK_MAX:
                            if (count_reg == '0)
                                status_next = mmh_pkg::ST_EMPTY;
                            else
                            begin
                                c_next     = '0;
                                state_next = S_RD;
                            end
                        mmh_pkg::OP_CLEAR:
                            count_next = '0;
                        default: ;
                    endcase
                    if (s_tdata[2:0] == mmh_pkg::OP_INSERT && count_reg == '0)
                        state_next = S_DONE;
                end
            end
            S_RD:
            begin
                raddr = '0;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (op_reg == mmh_pkg::OP_EXT_MIN || op_reg == mmh_pkg::OP_PEEK_MIN
                    || count_reg == CW'(1))
                begin
                    res_next   = rdata;
                    i_next     = '0;
                    state_next = S_PICK;
                end
                else if (count_reg == CW'(2))
                begin
                    raddr = AW'(1);
                    state_next = S_MAXW;
                    c_next     = XW'(1);
                end
                else
                begin
                    raddr = AW'(1);
                    state_next = S_MAXA;
                end
            end
            S_MAXA:
            begin
                best_next  = rdata;
                raddr      = AW'(2);
                state_next = S_MAXB;
            end
            S_MAXB:
            begin
                ca = rdata;
                cb = best_reg;
                // index 2 wins unless index 1 strictly larger
                if (lt)
                begin
                    res_next = best_reg;
                    i_next   = XW'(1);
                end
                else
                begin
                    res_next = rdata;
                    i_next   = XW'(2);
                end
                state_next = S_PICK;
            end
            S_MAXW:
            begin
                res_next   = rdata;
                i_next     = XW'(1);
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (op_reg == mmh_pkg::OP_EXT_MIN || op_reg == mmh_pkg::OP_EXT_MAX)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_LASTRD;
                end
                else
                    state_next = S_DONE;
            end
            S_LASTRD:
            begin
                raddr      = count_reg[AW-1:0];
                state_next = S_LASTW;
            end
            S_LASTW:
            begin
                key_next   = rdata;
                state_next = S_DNSTART;
            end
            S_DNSTART:
            begin
                // key_reg belongs at i_reg; write it now, overwrite if it moves
                we = 1'b1;
                if ((i_reg << 1) + XW'(1) < cnt_x)
                begin
                    mn_next    = mmh_pkg::on_min_level((CW+1)'(i_reg));
                    k_next     = '0;
                    c_next     = (i_reg << 1) + XW'(1);
                    state_next = S_DNCRD;
                end
                else
                    state_next = S_DONE;
            end
            S_DNCRD:
            begin
                state_next = S_DNCW;
            end
            S_DNCW:
            begin
                ca = mn_reg ? rdata : best_reg;
                cb = mn_reg ? best_reg : rdata;
                if (k_reg == '0 || lt)
                begin
                    best_next = rdata;
                    m_next    = c_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd5 || cand >= cnt_x)
                    state_next = S_DNCMP;
                else
                begin
                    c_next     = cand;
                    state_next = S_DNCRD;
                end
            end
            S_DNCMP:
            begin
                ca = mn_reg ? best_reg : key_reg;
                cb = mn_reg ? key_reg : best_reg;
                if (lt)
                begin
                    we         = 1'b1;
                    wdata      = best_reg;
                    state_next = S_DNSWAP;
                end
                else
                    state_next = S_DONE;
            end
            S_DNSWAP:
            begin
                if (m_reg >= (i_reg << 2) + XW'(3))
                begin
                    c_next     = (m_reg - 1'b1) >> 1;
                    state_next = S_DNPRD;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = m_reg[AW-1:0];
                    state_next = S_DONE;
                end
            end
            S_DNPRD:
            begin
                state_next = S_DNPW;
            end
            S_DNPW:
            begin
                ca = mn_reg ? rdata : key_reg;
                cb = mn_reg ? key_reg : rdata;
                if (lt)
                begin
                    we       = 1'b1;
                    waddr    = c_reg[AW-1:0];
                    key_next = rdata;
                    wdata    = key_reg;
                end
                i_next     = m_reg;
                state_next = S_DNSTART;
            end
            S_UPRD:
            begin
                c_next     = par_i;
                raddr      = par_i[AW-1:0];
                mn_next    = mmh_pkg::on_min_level((CW+1)'(i_reg));
                state_next = S_UPW;
            end
            S_UPW:
            begin
                // on min level: swap with parent if key > parent
                ca = mn_reg ? rdata : key_reg;
                cb = mn_reg ? key_reg : rdata;
                if (lt)
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    i_next     = c_reg;
                    mn_next    = !mn_reg;
                end
                state_next = S_CLRD;
            end
            S_CLRD:
            begin
                if (i_reg > XW'(2))
                begin
                    c_next     = gp_i;
                    state_next = S_CLW;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CLW:
            begin
                state_next = S_CLCMP;
            end
            S_CLCMP:
            begin
                ca = mn_reg ? key_reg : rdata;
                cb = mn_reg ? rdata : key_reg;
                if (lt)
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    i_next     = c_reg;
                    state_next = S_CLRD;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        best_reg   <= best_next;
        i_reg      <= i_next;
        m_reg      <= m_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        mn_reg     <= mn_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end
endmodule

// ----- rtl/mmh_checker.sv -----
// Port-level checker for the min-max heap, bound to the top level.
// Depends on mmh_pkg and on double_ended_priority_queue ports only.
module mmh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] <= mmh_pkg::ST_FULL)
        else $error("bad status");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[46:34] <= 13'(mmh_pkg::CAPACITY))
        else $error("count beyond capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a beat while busy");
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != mmh_pkg::ST_OK |-> m_tdata[33:2] == 32'd0)
        else $error("failed request returned a key");
endmodule

bind double_ended_priority_queue mmh_checker u_mmh_checker (.*);
